### hw/rtl/pdv_pkg.sv
// pdv_pkg: shared types, widths and constants for the pose difference velocity unit.
// Holds the word structs, the sequencer state type and the CORDIC arctangent table.
// No dependencies.
package pdv_pkg;

	// field widths of the words
	localparam int POS_W      = 32;
	localparam int HEAD_W     = 16;
	localparam int SPEED_W    = 48;
	localparam int DIR_W      = 16;
	localparam int TURN_W     = 24;
	localparam int RATE_W     = 10;

	// rate register value after reset
	localparam logic [RATE_W-1:0] RATE_RESET = 10'd100;

	// position step and CORDIC datapath
	localparam int DELTA_W      = POS_W + 1;
	localparam int GUARD_BITS   = 16;
	localparam int CORDIC_W     = 53;
	localparam int MAG_W        = CORDIC_W - 1;
	localparam int Z_W          = 30;
	localparam int CORDIC_STEPS = 20;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int ATAN_IDX_W   = 5;

	// angle accumulator counts degrees * 2^20; half turn is 180 degrees
	localparam logic signed [Z_W-1:0] HALF_TURN = 30'sd188743680;

	// gain correction: floor(mag * INV_GAIN / 2^32), one 4-bit digit per cycle
	localparam int GAIN_W      = 32;
	localparam logic [GAIN_W-1:0] INV_GAIN = 32'h9B74_EDA8;
	localparam int GAIN_DIG_W  = 4;
	localparam int GAIN_STEPS  = GAIN_W / GAIN_DIG_W;
	localparam int GCNT_W      = $clog2(GAIN_STEPS);
	localparam int GACC_W      = MAG_W + GAIN_DIG_W;

	// rate products, one rate bit per cycle
	localparam int RCNT_W      = $clog2(RATE_W);
	localparam int SPEED_ACC_W = MAG_W + RATE_W;
	localparam int HEAD_DIFF_W = HEAD_W + 1;
	localparam int TURN_ACC_W  = HEAD_DIFF_W + RATE_W + 1;

	// output scaling
	localparam logic [SPEED_ACC_W-1:0] SPEED_HALF =
		SPEED_ACC_W'(1) << (GUARD_BITS - 1);
	localparam int ANGLE_SHIFT = 13;
	localparam int DIR_FULL_W  = Z_W - ANGLE_SHIFT;
	localparam logic signed [Z_W-1:0] ANGLE_HALF = Z_W'(1) <<< (ANGLE_SHIFT - 1);
	localparam logic signed [DIR_FULL_W-1:0] DIR_MAX = DIR_FULL_W'(23040);
	localparam logic signed [DIR_FULL_W-1:0] DIR_MIN = -DIR_FULL_W'(23040);
	localparam logic signed [TURN_ACC_W-1:0] TURN_MAX = TURN_ACC_W'(8388607);
	localparam logic signed [TURN_ACC_W-1:0] TURN_MIN = -TURN_ACC_W'(8388608);

	// input word
	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [HEAD_W-1:0] heading;
	} pdv_in_t;

	// result word
	typedef struct packed {
		logic [SPEED_W-1:0]       speed;
		logic signed [DIR_W-1:0]  direction;
		logic signed [TURN_W-1:0] turn_rate;
	} pdv_out_t;

	// top-level sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CORDIC,
		ST_GAIN,
		ST_RATE,
		ST_FIN
	} pdv_state_t;

	// atan(2^-i) in degrees * 2^20, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			5'd0:    v = Z_W'(47185920);
			5'd1:    v = Z_W'(27855475);
			5'd2:    v = Z_W'(14718068);
			5'd3:    v = Z_W'(7471121);
			5'd4:    v = Z_W'(3750058);
			5'd5:    v = Z_W'(1876857);
			5'd6:    v = Z_W'(938658);
			5'd7:    v = Z_W'(469357);
			5'd8:    v = Z_W'(234682);
			5'd9:    v = Z_W'(117342);
			5'd10:   v = Z_W'(58671);
			5'd11:   v = Z_W'(29335);
			5'd12:   v = Z_W'(14668);
			5'd13:   v = Z_W'(7334);
			5'd14:   v = Z_W'(3667);
			5'd15:   v = Z_W'(1833);
			5'd16:   v = Z_W'(917);
			5'd17:   v = Z_W'(458);
			5'd18:   v = Z_W'(229);
			5'd19:   v = Z_W'(115);
			5'd20:   v = Z_W'(57);
			5'd21:   v = Z_W'(29);
			5'd22:   v = Z_W'(14);
			5'd23:   v = Z_W'(7);
			5'd24:   v = Z_W'(4);
			5'd25:   v = Z_W'(2);
			5'd26:   v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/pdv_cordic.sv
// pdv_cordic: iterative CORDIC in vectoring mode, one micro-rotation per clock.
// Yields the gained vector length and the angle in degrees * 2^20.
// Depends on pdv_pkg.
module pdv_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [pdv_pkg::DELTA_W-1:0]  dx,
	input  logic signed [pdv_pkg::DELTA_W-1:0]  dy,
	output logic                                done,
	output logic [pdv_pkg::MAG_W-1:0]           mag,
	output logic signed [pdv_pkg::Z_W-1:0]      angle
);

	logic signed [pdv_pkg::CORDIC_W-1:0] x_q, y_q, x_ld, y_ld, xs, ys;
	logic signed [pdv_pkg::Z_W-1:0]      z_q, z_ld, at;
	logic [pdv_pkg::ITER_W-1:0]          cnt_q;
	logic                                run_q, done_q;

	// step scaled by 2^16, sign-extended to the datapath width
	assign x_ld = {{(pdv_pkg::CORDIC_W - pdv_pkg::DELTA_W - pdv_pkg::GUARD_BITS){dx[pdv_pkg::DELTA_W-1]}},
		dx, {pdv_pkg::GUARD_BITS{1'b0}}};
	assign y_ld = {{(pdv_pkg::CORDIC_W - pdv_pkg::DELTA_W - pdv_pkg::GUARD_BITS){dy[pdv_pkg::DELTA_W-1]}},
		dy, {pdv_pkg::GUARD_BITS{1'b0}}};

	// half-turn pre-rotation for steps pointing to negative x
	always_comb begin
		if (dy[pdv_pkg::DELTA_W-1]) begin
			z_ld = -pdv_pkg::HALF_TURN;
		end else begin
			z_ld = pdv_pkg::HALF_TURN;
		end
	end

	// shifted operands (arithmetic shift floors) and table entry
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = pdv_pkg::atan_lut(pdv_pkg::ATAN_IDX_W'(cnt_q));

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + pdv_pkg::ITER_W'(1);
				if (cnt_q == pdv_pkg::ITER_W'(pdv_pkg::CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// x, y, z datapath
	always_ff @(posedge clk) begin
		if (start) begin
			if (dx[pdv_pkg::DELTA_W-1]) begin
				x_q <= -x_ld;
				y_q <= -y_ld;
				z_q <= z_ld;
			end else begin
				x_q <= x_ld;
				y_q <= y_ld;
				z_q <= '0;
			end
		end else if (run_q) begin
			if (!y_q[pdv_pkg::CORDIC_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done  = done_q;
	assign mag   = x_q[pdv_pkg::CORDIC_W-1] ? '0 : x_q[pdv_pkg::MAG_W-1:0];
	assign angle = z_q;

endmodule

### hw/rtl/pdv_gain_mul.sv
// pdv_gain_mul: digit-serial removal of the CORDIC gain, floor(mag * K / 2^32).
// The constant K is shifted out 4 bits a cycle, LSB digit first; the partial sum shifts right.
// Depends on pdv_pkg.
module pdv_gain_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pdv_pkg::MAG_W-1:0]  mag,
	output logic                       done,
	output logic [pdv_pkg::MAG_W-1:0]  len
);

	logic [pdv_pkg::GAIN_W-1:0]     g_sr_q;
	logic [pdv_pkg::MAG_W-1:0]      acc_q;
	logic [pdv_pkg::GAIN_DIG_W-1:0] dig;
	logic [pdv_pkg::GACC_W-1:0]     prod, sum;
	logic [pdv_pkg::GCNT_W-1:0]     cnt_q;
	logic                           run_q, done_q;

	// one digit of the constant times the magnitude, added to the carried sum
	assign dig  = g_sr_q[pdv_pkg::GAIN_DIG_W-1:0];
	assign prod = mag * dig;
	assign sum  = pdv_pkg::GACC_W'(acc_q) + prod;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + pdv_pkg::GCNT_W'(1);
				if (cnt_q == pdv_pkg::GCNT_W'(pdv_pkg::GAIN_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// constant shift register and right-shifting accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			g_sr_q <= pdv_pkg::INV_GAIN;
			acc_q  <= '0;
		end else if (run_q) begin
			g_sr_q <= g_sr_q >> pdv_pkg::GAIN_DIG_W;
			acc_q  <= sum[pdv_pkg::GACC_W-1:pdv_pkg::GAIN_DIG_W];
		end
	end

	assign done = done_q;
	assign len  = acc_q;

endmodule

### hw/rtl/pdv_rate_mul.sv
// pdv_rate_mul: bit-serial products of length and heading step with the sample rate.
// The rate is shifted out MSB first; both accumulators double and add each cycle.
// Depends on pdv_pkg.
module pdv_rate_mul (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [pdv_pkg::MAG_W-1:0]               len,
	input  logic signed [pdv_pkg::HEAD_DIFF_W-1:0]  dh,
	input  logic [pdv_pkg::RATE_W-1:0]              rate,
	output logic                                    done,
	output logic [pdv_pkg::SPEED_ACC_W-1:0]         len_prod,
	output logic signed [pdv_pkg::TURN_ACC_W-1:0]   turn_prod
);

	logic [pdv_pkg::RATE_W-1:0]             r_sr_q;
	logic [pdv_pkg::SPEED_ACC_W-1:0]        acc_q, len_term;
	logic signed [pdv_pkg::TURN_ACC_W-1:0]  tacc_q, turn_term;
	logic [pdv_pkg::RCNT_W-1:0]             cnt_q;
	logic                                   run_q, done_q, bit_now;

	// current rate bit selects the addends
	assign bit_now   = r_sr_q[pdv_pkg::RATE_W-1];
	assign len_term  = bit_now ? pdv_pkg::SPEED_ACC_W'(len) : '0;
	assign turn_term = bit_now ? pdv_pkg::TURN_ACC_W'(dh) : '0;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + pdv_pkg::RCNT_W'(1);
				if (cnt_q == pdv_pkg::RCNT_W'(pdv_pkg::RATE_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// rate shift register and the two shift-add accumulators
	always_ff @(posedge clk) begin
		if (start) begin
			r_sr_q <= rate;
			acc_q  <= '0;
			tacc_q <= '0;
		end else if (run_q) begin
			r_sr_q <= r_sr_q << 1;
			acc_q  <= (acc_q << 1) + len_term;
			tacc_q <= (tacc_q <<< 1) + turn_term;
		end
	end

	assign done      = done_q;
	assign len_prod  = acc_q;
	assign turn_prod = tacc_q;

endmodule

### hw/rtl/pose_difference_velocity_unit.sv
// Each word runs through the sequencer states PREP, CORDIC, GAIN, RATE and FIN in turn:
// the 20-step CORDIC, the 8-digit gain multiply and the 10-bit serial rate multiply, each
// begun by a load, then the output register is filled once it is free. A new input word is
// taken only in IDLE; a finished word may wait in the output register while the next is worked.
// Reset (arst_n low, asynchronous): sequencer idle, no result pending, sample rate 100,
// previous pose (0, 0, 0). Depends on pdv_pkg, pdv_cordic, pdv_gain_mul, pdv_rate_mul.
module pose_difference_velocity_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pdv_pkg::RATE_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  pdv_pkg::pdv_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output pdv_pkg::pdv_out_t            out_data
);

	pdv_pkg::pdv_state_t state_q, state_d;

	logic [pdv_pkg::RATE_W-1:0]              rate_q;
	logic signed [pdv_pkg::POS_W-1:0]        last_x_q, last_y_q;
	logic signed [pdv_pkg::HEAD_W-1:0]       last_h_q;
	logic signed [pdv_pkg::DELTA_W-1:0]      dx_q, dy_q;
	logic signed [pdv_pkg::HEAD_DIFF_W-1:0]  dh_q;
	logic                                    zero_q;
	pdv_pkg::pdv_out_t                       out_q;
	logic                                    out_valid_q;

	logic in_fire, out_fire, out_load;
	logic cordic_start, gain_start, rate_start;
	logic cordic_done, gain_done, rate_done;
	logic [pdv_pkg::MAG_W-1:0]               mag, len;
	logic signed [pdv_pkg::Z_W-1:0]          angle, z_rnd;
	logic [pdv_pkg::SPEED_ACC_W-1:0]         len_prod, spd_rnd;
	logic signed [pdv_pkg::TURN_ACC_W-1:0]   turn_prod;
	logic signed [pdv_pkg::DIR_FULL_W-1:0]   dir_full, dir_sat;
	logic signed [pdv_pkg::TURN_ACC_W-1:0]   turn_sat;

	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid_q & out_ready;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= pdv_pkg::RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rate_q <= cfg_data;
		end
	end

	// previous pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			last_h_q <= '0;
		end else if (in_fire) begin
			last_x_q <= $signed(in_data.pos_x);
			last_y_q <= $signed(in_data.pos_y);
			last_h_q <= $signed(in_data.heading);
		end
	end

	// pose differences, taken exactly at acceptance
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dx_q   <= pdv_pkg::DELTA_W'($signed(in_data.pos_x)) - pdv_pkg::DELTA_W'(last_x_q);
			dy_q   <= pdv_pkg::DELTA_W'($signed(in_data.pos_y)) - pdv_pkg::DELTA_W'(last_y_q);
			dh_q   <= pdv_pkg::HEAD_DIFF_W'($signed(in_data.heading))
				- pdv_pkg::HEAD_DIFF_W'(last_h_q);
			zero_q <= (in_data.pos_x == last_x_q) && (in_data.pos_y == last_y_q);
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pdv_pkg::ST_IDLE:   if (in_fire) state_d = pdv_pkg::ST_PREP;
			pdv_pkg::ST_PREP:   state_d = pdv_pkg::ST_CORDIC;
			pdv_pkg::ST_CORDIC: if (cordic_done) state_d = pdv_pkg::ST_GAIN;
			pdv_pkg::ST_GAIN:   if (gain_done) state_d = pdv_pkg::ST_RATE;
			pdv_pkg::ST_RATE:   if (rate_done) state_d = pdv_pkg::ST_FIN;
			pdv_pkg::ST_FIN:    if (!out_valid_q || out_ready) state_d = pdv_pkg::ST_IDLE;
			default:            state_d = pdv_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready     = 1'b0;
		cordic_start = 1'b0;
		gain_start   = 1'b0;
		rate_start   = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			pdv_pkg::ST_IDLE:   in_ready = 1'b1;
			pdv_pkg::ST_PREP:   cordic_start = 1'b1;
			pdv_pkg::ST_CORDIC: gain_start = cordic_done;
			pdv_pkg::ST_GAIN:   rate_start = gain_done;
			pdv_pkg::ST_RATE:   ;
			pdv_pkg::ST_FIN:    out_load = !out_valid_q || out_ready;
			default:            ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	pdv_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.dx     (dx_q),
		.dy     (dy_q),
		.done   (cordic_done),
		.mag    (mag),
		.angle  (angle)
	);

	pdv_gain_mul u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gain_start),
		.mag    (mag),
		.done   (gain_done),
		.len    (len)
	);

	pdv_rate_mul u_rate (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rate_start),
		.len       (len),
		.dh        (dh_q),
		.rate      (rate_q),
		.done      (rate_done),
		.len_prod  (len_prod),
		.turn_prod (turn_prod)
	);

	// rounding and clamping of the final values
	assign spd_rnd  = len_prod + pdv_pkg::SPEED_HALF;
	assign z_rnd    = angle + pdv_pkg::ANGLE_HALF;
	assign dir_full = z_rnd[pdv_pkg::Z_W-1:pdv_pkg::ANGLE_SHIFT];

	always_comb begin
		if (dir_full > pdv_pkg::DIR_MAX) begin
			dir_sat = pdv_pkg::DIR_MAX;
		end else if (dir_full < pdv_pkg::DIR_MIN) begin
			dir_sat = pdv_pkg::DIR_MIN;
		end else begin
			dir_sat = dir_full;
		end
		if (turn_prod > pdv_pkg::TURN_MAX) begin
			turn_sat = pdv_pkg::TURN_MAX;
		end else if (turn_prod < pdv_pkg::TURN_MIN) begin
			turn_sat = pdv_pkg::TURN_MIN;
		end else begin
			turn_sat = turn_prod;
		end
	end

	// output register: a finished word waits here while the next is being worked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (zero_q) begin
				out_q.speed     <= '0;
				out_q.direction <= '0;
			end else begin
				out_q.speed     <= pdv_pkg::SPEED_W'(
					spd_rnd[pdv_pkg::SPEED_ACC_W-1:pdv_pkg::GUARD_BITS]);
				out_q.direction <= dir_sat[pdv_pkg::DIR_W-1:0];
			end
			out_q.turn_rate <= turn_sat[pdv_pkg::TURN_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hw/rtl/pdv_checker.sv
// pdv_checker: port-level checks of the pose difference velocity unit over time.
// Bound to pose_difference_velocity_unit below. Depends on pdv_pkg.
module pdv_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input pdv_pkg::pdv_out_t            out_data
);

	logic in_fire;
	logic cfg_fire;
	assign in_fire  = in_valid & in_ready;
	assign cfg_fire = cfg_valid & cfg_ready;

	// one word at a time: no second word straight after an accepted one
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken while previous word still in work");

	// the serial datapath keeps the input closed: checked low once, well into the run
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> ##30 !in_ready)
		else $error("input reopened before the serial work could finish");

	// a result appears only at the end of a run, when the input has been closed
	a_result_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word appeared without a run behind it");

	// the rate register is always writable
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_fire)
		else $error("configuration write refused");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped or changed while stalled");

endmodule

bind pose_difference_velocity_unit pdv_checker u_pdv_checker (.*);
